[hw/rtl/pels_pkg.sv]
// ----------------------------------------------------------------------------
// pels_pkg
// Shared types and constants of the pairwise exchange local search block.
// ----------------------------------------------------------------------------
package pels_pkg;

  localparam int FAC_W      = 5;
  localparam int LIST_DEPTH = 32;
  localparam int OPC_W      = 3;
  localparam int VAL_W      = 16;
  localparam int SIZE_W     = 6;
  localparam int START_W    = 5;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int COST_BITS  = 44;
  localparam int SWAP_W     = 11;
  localparam logic [SWAP_W-1:0] SWAP_LIMIT = 11'd1024;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_FLOW = 3'd0,
    OP_LOAD_DIST = 3'd1,
    OP_LOAD_ASG  = 3'd2,
    OP_LOAD_LIST = 3'd3,
    OP_RUN       = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE  = 2'd0,
    CFG_START = 2'd1,
    CFG_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COST,
    ST_COST_DRAIN,
    ST_SCAN,
    ST_PAIR_CHK,
    ST_PAIR_I,
    ST_PAIR_J,
    ST_PAIR_CAP,
    ST_TERMS,
    ST_PAIR_DRAIN,
    ST_SWAP_RD,
    ST_SWAP_W0,
    ST_SWAP_W1,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // One product term: sign * flow(fx,fy) * dist(loc(dr),loc(dc))
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [FAC_W-1:0] fx;
    logic [FAC_W-1:0] fy;
    logic [FAC_W-1:0] dr;
    logic [FAC_W-1:0] dc;
  } pels_op_t;

  typedef struct packed {
    logic             flow_we;
    logic             dist_we;
    logic             asg_we;
    logic             list_we;
    logic [FAC_W-1:0] row;
    logic [FAC_W-1:0] col;
    logic [VAL_W-1:0] value;
  } pels_wr_t;

  typedef struct packed {
    logic [FAC_W-1:0] asg_a;
    logic [FAC_W-1:0] asg_b;
    logic [FAC_W-1:0] list_a;
  } pels_rd_t;

  typedef struct packed {
    logic             busy;
    logic [FAC_W-1:0] loc_a;
    logic [FAC_W-1:0] loc_b;
    logic [FAC_W-1:0] list_q;
  } pels_stat_t;

endpackage

[hw/rtl/pels_in_if.sv]
// ----------------------------------------------------------------------------
// pels_in_if
// Input channel: load and run beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pels_in_if;
  logic                         valid;
  logic                         ready;
  logic [pels_pkg::OPC_W-1:0]   opcode;
  logic [pels_pkg::FAC_W-1:0]   row;
  logic [pels_pkg::FAC_W-1:0]   col;
  logic [pels_pkg::VAL_W-1:0]   value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

[hw/rtl/pels_out_if.sv]
// ----------------------------------------------------------------------------
// pels_out_if
// Output channel: one beat per facility of the final assignment.
// ----------------------------------------------------------------------------
interface pels_out_if;
  logic                           valid;
  logic                           ready;
  logic [pels_pkg::FAC_W-1:0]     position;
  logic [pels_pkg::FAC_W-1:0]     location;
  logic [pels_pkg::COST_BITS-1:0] total_cost;
  logic                           last;

  modport source (output valid, position, location, total_cost, last, input ready);
  modport sink   (input valid, position, location, total_cost, last, output ready);
endinterface

[hw/rtl/pairwise_exchange_local_search_top.sv]
// ----------------------------------------------------------------------------
// pairwise_exchange_local_search_top
// Quadratic assignment local search by pairwise exchange of facilities.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load beats (flow entry, distance entry, assignment entry,
//   swap list entry) and run beats. A run computes the assignment cost, then
//   scans all list pairs from start_position on, applies the best improving
//   swap, and repeats until no swap improves or SWAP_LIMIT swaps are made.
//   out_ch then carries n beats, facility 0..n-1, last on the final one.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are the user's to make only
//   while idle; the block itself does not enforce this.
// Throughput:
//   the single read port of each matrix sets the pace: one product term per
//   cycle; the symmetric mode needs fewer terms per pair than the asymmetric one.
//   Emission reads each beat's location, then loads the result register.
// Reset: control returns to idle with default configuration; matrix,
//   assignment and list contents are kept undefined until loaded.
// Stall: the result register holds its beat until out_ch.ready; emission
//   waits on it, and a new beat is accepted only when the block is idle.
// ----------------------------------------------------------------------------
module pairwise_exchange_local_search_top #(
  parameter int MAX_SIZE   = 32,
  parameter int ENTRY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pels_in_if.sink                             in_ch,
  pels_out_if.source                          out_ch,
  input  logic                                cfg_we_i,
  input  logic [pels_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pels_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pels_pkg::*;

  localparam int ACC_W   = 2 * ENTRY_BITS + 12;
  localparam int DELTA_W = ACC_W + 1;
  localparam int COST_W  = (ACC_W + 12 > COST_BITS + 2) ? ACC_W + 12 : COST_BITS + 2;
  localparam logic [CNT_W-1:0] NCAP = CNT_W'((MAX_SIZE < 32) ? MAX_SIZE : 32);

  function automatic logic [COST_BITS-1:0] clamp(input logic signed [COST_W-1:0] c);
    logic [COST_BITS-1:0] r;
    if (c[COST_W-1]) begin
      r = '0;
    end else if (|c[COST_W-2:COST_BITS]) begin
      r = '1;
    end else begin
      r = c[COST_BITS-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  size_q;
  logic [START_W-1:0] start_q;
  logic               mode_q;

  logic [CNT_W-1:0]   s_q, s_d, t_q, t_d, k_q, k_d;
  logic [2:0]         sub_q, sub_d;
  logic               cphase_q, cphase_d;
  logic [FAC_W-1:0]   fi_q, fi_d, fj_q, fj_d, a0_q, a0_d, a1_q, a1_d, tmp_q, tmp_d;
  logic [SWAP_W-1:0]  swaps_q, swaps_d;
  logic signed [DELTA_W-1:0] best_q, best_d, delta;
  logic signed [COST_W-1:0]  cost_q, cost_d;
  logic [COST_BITS-1:0]      fin_q, fin_d;

  logic [CNT_W-1:0]   n_eff;
  logic [2:0]         last_sub;
  logic               skip, in_fire, out_free, emit_ld, mac_clr;

  pels_wr_t   wr;
  pels_rd_t   rd;
  pels_op_t   op, term_op;
  pels_stat_t stat;
  logic signed [ACC_W-1:0] acc;

  logic                 out_valid_q, out_last_q;
  logic [FAC_W-1:0]     out_pos_q, out_loc_q;
  logic [COST_BITS-1:0] out_cost_q;

  pels_mac_mem #(
    .MAX_SIZE   (MAX_SIZE),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_mac_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .rd_i   (rd),
    .op_i   (op),
    .clr_i  (mac_clr),
    .stat_o (stat),
    .acc_o  (acc)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_W'(32);
      start_q <= '0;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_START: start_q <= cfg_data_i[START_W-1:0];
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // effective size and helpers
  always_comb begin
    if (size_q < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (size_q > NCAP) begin
      n_eff = NCAP;
    end else begin
      n_eff = size_q;
    end
    last_sub = mode_q ? 3'd3 : 3'd7;
    skip     = (k_q == CNT_W'(fi_q)) || (k_q == CNT_W'(fj_q));
    delta    = mode_q ? (DELTA_W'(acc) <<< 1) : DELTA_W'(acc);
    in_fire  = in_ch.valid && in_ch.ready;
    out_free = !out_valid_q || out_ch.ready;
  end

  // product term of the swap delta
  always_comb begin
    logic [FAC_W-1:0] i, j, kk;
    i  = fi_q;
    j  = fj_q;
    kk = k_q[FAC_W-1:0];
    term_op       = '0;
    term_op.valid = cphase_q || ((k_q != n_eff) && !skip);
    if (cphase_q) begin
      unique case (sub_q)
        3'd0:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, i, i, j, j};
        3'd1:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, i, i, i, i};
        3'd2:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, i, j, j, i};
        3'd3:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, i, j, i, j};
        3'd4:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, j, i, i, j};
        3'd5:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, j, i, j, i};
        3'd6:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, j, j, i, i};
        default: {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, j, j, j, j};
      endcase
    end else if (mode_q) begin
      unique case (sub_q[1:0])
        2'd0:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, j, kk, i, kk};
        2'd1:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, j, kk, j, kk};
        2'd2:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, i, kk, i, kk};
        default: {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, i, kk, j, kk};
      endcase
    end else begin
      unique case (sub_q)
        3'd0:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, kk, i, kk, j};
        3'd1:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, kk, i, kk, i};
        3'd2:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, kk, j, kk, i};
        3'd3:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, kk, j, kk, j};
        3'd4:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, i, kk, j, kk};
        3'd5:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, i, kk, i, kk};
        3'd6:    {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b0, j, kk, i, kk};
        default: {term_op.neg, term_op.fx, term_op.fy, term_op.dr, term_op.dc} = {1'b1, j, kk, j, kk};
      endcase
    end
  end

  // next state and sequencer registers
  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    t_d      = t_q;
    k_d      = k_q;
    sub_d    = sub_q;
    cphase_d = cphase_q;
    fi_d     = fi_q;
    fj_d     = fj_q;
    a0_d     = a0_q;
    a1_d     = a1_q;
    tmp_d    = tmp_q;
    swaps_d  = swaps_q;
    best_d   = best_q;
    cost_d   = cost_q;
    fin_d    = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_ch.opcode == OP_RUN)) begin
          s_d     = '0;
          t_d     = '0;
          swaps_d = '0;
          state_d = ST_COST;
        end
      end
      ST_COST: begin
        if (t_q == n_eff - CNT_W'(1)) begin
          t_d = '0;
          s_d = s_q + CNT_W'(1);
          if (s_q == n_eff - CNT_W'(1)) begin
            state_d = ST_COST_DRAIN;
          end
        end else begin
          t_d = t_q + CNT_W'(1);
        end
      end
      ST_COST_DRAIN: begin
        if (!stat.busy) begin
          cost_d  = COST_W'(acc);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        best_d  = '0;
        a0_d    = '0;
        a1_d    = '0;
        s_d     = CNT_W'(start_q);
        t_d     = CNT_W'(start_q) + CNT_W'(1);
        state_d = ST_PAIR_CHK;
      end
      ST_PAIR_CHK: begin
        if (t_q < n_eff) begin
          state_d = ST_PAIR_I;
        end else if (best_q < 0) begin
          state_d = ST_SWAP_RD;
        end else begin
          fin_d   = clamp(cost_q);
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end
      end
      ST_PAIR_I: state_d = ST_PAIR_J;
      ST_PAIR_J: begin
        fi_d    = stat.list_q;
        state_d = ST_PAIR_CAP;
      end
      ST_PAIR_CAP: begin
        fj_d     = stat.list_q;
        k_d      = '0;
        sub_d    = '0;
        cphase_d = !mode_q;
        state_d  = ST_TERMS;
      end
      ST_TERMS: begin
        if (cphase_q) begin
          sub_d = sub_q + 3'd1;
          if (sub_q == 3'd7) begin
            cphase_d = 1'b0;
          end
        end else if (k_q == n_eff) begin
          state_d = ST_PAIR_DRAIN;
        end else if (skip) begin
          k_d = k_q + CNT_W'(1);
        end else if (sub_q == last_sub) begin
          sub_d = '0;
          k_d   = k_q + CNT_W'(1);
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      ST_PAIR_DRAIN: begin
        if (!stat.busy) begin
          if (delta < best_q) begin
            best_d = delta;
            a0_d   = fi_q;
            a1_d   = fj_q;
          end
          if (t_q + CNT_W'(1) < n_eff) begin
            t_d = t_q + CNT_W'(1);
          end else begin
            s_d = s_q + CNT_W'(1);
            t_d = s_q + CNT_W'(2);
          end
          state_d = ST_PAIR_CHK;
        end
      end
      ST_SWAP_RD: state_d = ST_SWAP_W0;
      ST_SWAP_W0: begin
        tmp_d   = stat.loc_a;
        cost_d  = cost_q + COST_W'(best_q);
        swaps_d = swaps_q + SWAP_W'(1);
        state_d = ST_SWAP_W1;
      end
      ST_SWAP_W1: begin
        if (swaps_q == SWAP_LIMIT) begin
          fin_d   = clamp(cost_q);
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        k_d     = k_q + CNT_W'(1);
        state_d = (k_q == n_eff - CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory ports, pipeline issue and handshake
  always_comb begin
    wr       = '0;
    rd       = '0;
    op       = '0;
    mac_clr  = 1'b0;
    emit_ld  = 1'b0;
    wr.row   = in_ch.row;
    wr.col   = in_ch.col;
    wr.value = in_ch.value;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_LOAD_FLOW: wr.flow_we = 1'b1;
            OP_LOAD_DIST: wr.dist_we = 1'b1;
            OP_LOAD_ASG:  wr.asg_we  = 1'b1;
            OP_LOAD_LIST: wr.list_we = 1'b1;
            OP_RUN:       mac_clr    = 1'b1;
            default:      ;
          endcase
        end
      end
      ST_COST: begin
        op.valid = 1'b1;
        op.fx    = s_q[FAC_W-1:0];
        op.fy    = t_q[FAC_W-1:0];
        op.dr    = s_q[FAC_W-1:0];
        op.dc    = t_q[FAC_W-1:0];
        rd.asg_a = s_q[FAC_W-1:0];
        rd.asg_b = t_q[FAC_W-1:0];
      end
      ST_PAIR_I:   rd.list_a = s_q[FAC_W-1:0];
      ST_PAIR_J:   rd.list_a = t_q[FAC_W-1:0];
      ST_PAIR_CAP: mac_clr   = 1'b1;
      ST_TERMS: begin
        op       = term_op;
        rd.asg_a = term_op.dr;
        rd.asg_b = term_op.dc;
      end
      ST_SWAP_RD: begin
        rd.asg_a = a0_q;
        rd.asg_b = a1_q;
      end
      ST_SWAP_W0: begin
        wr.asg_we = 1'b1;
        wr.row    = a0_q;
        wr.value  = VAL_W'(stat.loc_b);
      end
      ST_SWAP_W1: begin
        wr.asg_we = 1'b1;
        wr.row    = a1_q;
        wr.value  = VAL_W'(tmp_q);
      end
      ST_EMIT_RD: rd.asg_a = k_q[FAC_W-1:0];
      ST_EMIT_LD: emit_ld  = 1'b1;
      default:    ;
    endcase
  end

  assign in_ch.ready = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      s_q      <= '0;
      t_q      <= '0;
      k_q      <= '0;
      sub_q    <= '0;
      cphase_q <= 1'b0;
      swaps_q  <= '0;
      best_q   <= '0;
      cost_q   <= '0;
      a0_q     <= '0;
      a1_q     <= '0;
    end else begin
      state_q  <= state_d;
      s_q      <= s_d;
      t_q      <= t_d;
      k_q      <= k_d;
      sub_q    <= sub_d;
      cphase_q <= cphase_d;
      swaps_q  <= swaps_d;
      best_q   <= best_d;
      cost_q   <= cost_d;
      a0_q     <= a0_d;
      a1_q     <= a1_d;
    end
  end

  // pair and emission payload
  always_ff @(posedge clk_i) begin
    fi_q  <= fi_d;
    fj_q  <= fj_d;
    tmp_q <= tmp_d;
    fin_q <= fin_d;
  end

  // result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ld) begin
      out_pos_q  <= k_q[FAC_W-1:0];
      out_loc_q  <= stat.loc_a;
      out_cost_q <= fin_q;
      out_last_q <= (k_q == n_eff - CNT_W'(1));
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.position   = out_pos_q;
  assign out_ch.location   = out_loc_q;
  assign out_ch.total_cost = out_cost_q;
  assign out_ch.last       = out_last_q;

endmodule

[hw/rtl/pels_mac_mem.sv]
// ----------------------------------------------------------------------------
// pels_mac_mem
// Problem storage and the product/accumulate pipeline: assignment read,
// matrix read, multiply, signed accumulate.
// ----------------------------------------------------------------------------
module pels_mac_mem #(
  parameter int MAX_SIZE   = 32,
  parameter int ENTRY_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pels_pkg::pels_wr_t              wr_i,
  input  pels_pkg::pels_rd_t              rd_i,
  input  pels_pkg::pels_op_t              op_i,
  input  logic                            clr_i,
  output pels_pkg::pels_stat_t            stat_o,
  output logic signed [2*ENTRY_BITS+11:0] acc_o
);
  import pels_pkg::*;

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * ENTRY_BITS;
  localparam int ACC_W = 2 * ENTRY_BITS + 12;
  localparam logic [6:0] MAX_N = 7'(MAX_SIZE);

  function automatic logic in_rng(input logic [FAC_W-1:0] v);
    return 7'(v) < MAX_N;
  endfunction

  function automatic logic [AW-1:0] mat_addr(input logic [FAC_W-1:0] r,
                                             input logic [FAC_W-1:0] c);
    return AW'(AW'(r) * AW'(MAX_SIZE) + AW'(c));
  endfunction

  logic [ENTRY_BITS-1:0] flow_mem [DEPTH];
  logic [ENTRY_BITS-1:0] dist_mem [DEPTH];
  logic [FAC_W-1:0]      asg_mem  [LIST_DEPTH];
  logic [FAC_W-1:0]      list_mem [LIST_DEPTH];

  logic [FAC_W-1:0]      loc_a_q, loc_b_q, list_q;
  logic [ENTRY_BITS-1:0] flow_rd_q, dist_rd_q;
  logic [AW-1:0]         waddr, f_raddr, d_raddr;
  logic                  w_ok, f_ok, d_ok;

  logic                  v1_q, v2_q, v3_q;
  logic                  neg1_q, neg2_q, neg3_q;
  logic [FAC_W-1:0]      fx1_q, fy1_q;
  logic                  f_ok2_q, d_ok2_q;
  logic [PW-1:0]         prod_q;
  logic [ENTRY_BITS-1:0] fa, db;
  logic signed [ACC_W-1:0] acc_q;

  // address generation
  always_comb begin
    w_ok    = in_rng(wr_i.row) && in_rng(wr_i.col);
    waddr   = w_ok ? mat_addr(wr_i.row, wr_i.col) : '0;
    f_ok    = in_rng(fx1_q) && in_rng(fy1_q);
    d_ok    = in_rng(loc_a_q) && in_rng(loc_b_q);
    f_raddr = f_ok ? mat_addr(fx1_q, fy1_q) : '0;
    d_raddr = d_ok ? mat_addr(loc_a_q, loc_b_q) : '0;
  end

  // flow matrix
  always_ff @(posedge clk_i) begin
    if (wr_i.flow_we && w_ok) begin
      flow_mem[waddr] <= ENTRY_BITS'(wr_i.value);
    end
    flow_rd_q <= flow_mem[f_raddr];
  end

  // distance matrix
  always_ff @(posedge clk_i) begin
    if (wr_i.dist_we && w_ok) begin
      dist_mem[waddr] <= ENTRY_BITS'(wr_i.value);
    end
    dist_rd_q <= dist_mem[d_raddr];
  end

  // assignment, two read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.asg_we) begin
      asg_mem[wr_i.row] <= wr_i.value[FAC_W-1:0];
    end
    loc_a_q <= asg_mem[rd_i.asg_a];
    loc_b_q <= asg_mem[rd_i.asg_b];
  end

  // swap list
  always_ff @(posedge clk_i) begin
    if (wr_i.list_we) begin
      list_mem[wr_i.row] <= wr_i.value[FAC_W-1:0];
    end
    list_q <= list_mem[rd_i.list_a];
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= op_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    neg1_q  <= op_i.neg;
    fx1_q   <= op_i.fx;
    fy1_q   <= op_i.fy;
    neg2_q  <= neg1_q;
    f_ok2_q <= f_ok;
    d_ok2_q <= d_ok;
    neg3_q  <= neg2_q;
    prod_q  <= PW'(fa) * PW'(db);
  end

  // drop out-of-range reads to zero
  assign fa = f_ok2_q ? flow_rd_q : '0;
  assign db = d_ok2_q ? dist_rd_q : '0;

  // accumulate signed products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clr_i) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= neg3_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o         = acc_q;
  assign stat_o.busy   = v1_q | v2_q | v3_q;
  assign stat_o.loc_a  = loc_a_q;
  assign stat_o.loc_b  = loc_b_q;
  assign stat_o.list_q = list_q;

endmodule

[hw/rtl/pels_chk.sv]
// ----------------------------------------------------------------------------
// pels_chk
// Port-level checks of the pairwise exchange local search block.
// ----------------------------------------------------------------------------
module pels_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                out_last_i,
  input logic [pels_pkg::COST_BITS-1:0]      out_cost_i
);
  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // no input beat taken in the middle of a result burst
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready during result burst");

  // nothing follows the final beat without a new run
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("result beat after final beat");

  // one cost across a burst
  a_cost_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> $stable(out_cost_i))
    else $error("cost changed within a burst");

endmodule

bind pairwise_exchange_local_search_top pels_chk u_pels_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_last_i  (out_ch.last),
  .out_cost_i  (out_ch.total_cost)
);

[sim/tb_pairwise_exchange_local_search_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pairwise_exchange_local_search_top
// Loads flow, distance, assignment and swap list entries, issues run beats
// and checks every emitted assignment beat and its final cost against a
// local predictor of the pairwise exchange search, under random idling.
// ----------------------------------------------------------------------------
module tb_pairwise_exchange_local_search_top;
  import pels_pkg::*;

  localparam int NFAC           = 32;
  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 600;

  typedef struct packed {
    logic [OPC_W-1:0] opc;
    logic [FAC_W-1:0] row;
    logic [FAC_W-1:0] col;
    logic [VAL_W-1:0] value;
  } load_beat_t;

  typedef struct packed {
    logic [FAC_W-1:0]     position;
    logic [FAC_W-1:0]     location;
    logic [COST_BITS-1:0] total_cost;
    logic                 last;
  } asg_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pels_in_if  in_ch ();
  pels_out_if out_ch ();

  pairwise_exchange_local_search_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.opcode = '0;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
  end

  // Predictor state: stores and configuration as the block should hold them
  logic [VAL_W-1:0] flow_m [NFAC][NFAC];
  logic [VAL_W-1:0] dist_m [NFAC][NFAC];
  logic [FAC_W-1:0] fac_loc [NFAC];
  logic [FAC_W-1:0] swap_fac [NFAC];
  int               size_cfg = 32;
  int               start_cfg = 0;
  bit               sym_mode = 1'b0;

  load_beat_t pending_q [$];
  asg_beat_t  expected_beats [$];
  int         src_pct = 0;
  int         snk_pct = 0;
  bit         hold_req = 1'b0;
  int         n_errors = 0;
  int         n_loads = 0;
  int         n_runs = 0;
  int         n_checked = 0;

  function automatic longint fl(int r, int c);
    return longint'(flow_m[r][c]);
  endfunction

  function automatic longint ds(int r, int c);
    return longint'(dist_m[r][c]);
  endfunction

  function automatic longint asym_delta(int i, int j, int n);
    int pi, pj, pk;
    longint d;
    pi = fac_loc[i];
    pj = fac_loc[j];
    d = fl(i, i) * (ds(pj, pj) - ds(pi, pi)) + fl(i, j) * (ds(pj, pi) - ds(pi, pj))
      + fl(j, i) * (ds(pi, pj) - ds(pj, pi)) + fl(j, j) * (ds(pi, pi) - ds(pj, pj));
    for (int k = 0; k < n; k++) begin
      if (k != i && k != j) begin
        pk = fac_loc[k];
        d += fl(k, i) * (ds(pk, pj) - ds(pk, pi)) + fl(k, j) * (ds(pk, pi) - ds(pk, pj))
           + fl(i, k) * (ds(pj, pk) - ds(pi, pk)) + fl(j, k) * (ds(pi, pk) - ds(pj, pk));
      end
    end
    return d;
  endfunction

  function automatic longint sym_delta(int i, int j, int n);
    int pi, pj;
    longint d;
    pi = fac_loc[i];
    pj = fac_loc[j];
    d = 0;
    for (int k = 0; k < n; k++) begin
      if (k != i && k != j) begin
        d += (fl(j, k) - fl(i, k)) * (ds(pi, fac_loc[k]) - ds(pj, fac_loc[k]));
      end
    end
    return d * 2;
  endfunction

  // Run: cost pass, best-improvement swaps until none improves or SWAP_LIMIT is hit, then emit
  function automatic void search_and_emit();
    int        n, a0, a1;
    longint    cost, best, d;
    logic [FAC_W-1:0] tmp;
    asg_beat_t b;
    n = size_cfg;
    if (n < 2) n = 2;
    if (n > NFAC) n = NFAC;
    cost = 0;
    for (int s = 0; s < n; s++)
      for (int t = 0; t < n; t++)
        cost += fl(s, t) * ds(fac_loc[s], fac_loc[t]);
    for (int swaps = 0; swaps < int'(SWAP_LIMIT); swaps++) begin
      best = 0;
      a0 = 0;
      a1 = 0;
      for (int s = start_cfg; s < n; s++) begin
        for (int t = s + 1; t < n; t++) begin
          d = sym_mode ? sym_delta(swap_fac[s], swap_fac[t], n)
                       : asym_delta(swap_fac[s], swap_fac[t], n);
          if (d < best) begin
            best = d;
            a0 = swap_fac[s];
            a1 = swap_fac[t];
          end
        end
      end
      if (best >= 0) break;
      tmp = fac_loc[a0];
      fac_loc[a0] = fac_loc[a1];
      fac_loc[a1] = tmp;
      cost += best;
    end
    if (cost < 0) cost = 0;
    if (cost > (64'd1 << COST_BITS) - 1) cost = (64'd1 << COST_BITS) - 1;
    for (int k = 0; k < n; k++) begin
      b.position   = FAC_W'(k);
      b.location   = fac_loc[k];
      b.total_cost = cost[COST_BITS-1:0];
      b.last       = (k == n - 1);
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void take_beat(load_beat_t x);
    case (opcode_e'(x.opc))
      OP_LOAD_FLOW: flow_m[x.row][x.col] = x.value;
      OP_LOAD_DIST: dist_m[x.row][x.col] = x.value;
      OP_LOAD_ASG:  fac_loc[x.row] = x.value[FAC_W-1:0];
      OP_LOAD_LIST: swap_fac[x.row] = x.value[FAC_W-1:0];
      OP_RUN: begin
        search_and_emit();
        n_runs++;
      end
      default: ;
    endcase
    if (x.opc < OP_RUN) n_loads++;
  endfunction

  // Sender: hold the offered beat until taken, then advance or idle
  load_beat_t cur_beat;
  always @(posedge clk_i) begin
    load_beat_t nxt;
    bit         offer;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) take_beat(cur_beat);
      if (!in_ch.valid || in_ch.ready) begin
        offer = pending_q.size() > 0 && $urandom_range(99) >= src_pct;
        if (offer) begin
          nxt = pending_q.pop_front();
          cur_beat     <= nxt;
          in_ch.opcode <= nxt.opc;
          in_ch.row    <= nxt.row;
          in_ch.col    <= nxt.col;
          in_ch.value  <= nxt.value;
        end
        in_ch.valid <= offer;
      end
    end
  end

  // Receiver: check each beat against the oldest expectation; stall at random
  int hold_left = 0;
  always @(posedge clk_i) begin
    asg_beat_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: position %0d", out_ch.position);
          n_errors++;
        end else begin
          e = expected_beats.pop_front();
          n_checked++;
          if (out_ch.position !== e.position) begin
            $error("position mismatch: expected %0d, got %0d", e.position, out_ch.position);
            n_errors++;
          end
          if (out_ch.location !== e.location) begin
            $error("location mismatch: expected %0d, got %0d", e.location, out_ch.location);
            n_errors++;
          end
          if (out_ch.total_cost !== e.total_cost) begin
            $error("total_cost mismatch: expected %0d, got %0d", e.total_cost,
                   out_ch.total_cost);
            n_errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last mismatch: expected %0d, got %0d", e.last, out_ch.last);
            n_errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= snk_pct;
      end
    end
  end

  // Watchdog: end the run after a long stretch with no beat moving
  int quiet = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d beats still expected", expected_beats.size());
        $display("tb_pairwise_exchange_local_search_top: errors");
        $finish;
      end
    end
  end

  task automatic push_beat(opcode_e op, int r, int c, int v);
    load_beat_t x;
    x.opc   = op;
    x.row   = FAC_W'(r);
    x.col   = FAC_W'(c);
    x.value = VAL_W'(v);
    pending_q.push_back(x);
  endtask

  // Symmetric off-diagonal write keeps the symmetric delta exact
  task automatic push_pair(opcode_e op, int r, int c, int v);
    push_beat(op, r, c, v);
    if (r != c) push_beat(op, c, r, v);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_ch.valid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, int v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(v);
    case (idx)
      CFG_SIZE:  size_cfg  = v & 63;
      CFG_START: start_cfg = v & 31;
      CFG_MODE:  sym_mode  = v[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    src_pct = (mode == 1) ? 60 : (mode == 3) ? 16 : 0;
    snk_pct = (mode == 2) ? 60 : (mode == 3) ? 16 : 0;
  endtask

  initial begin
    int n;
    int perm [NFAC];
    int j, tmp, r, c, v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every store entry: symmetric matrices with zero diagonal, identity lists
    for (int a = 0; a < NFAC; a++) begin
      for (int b = a; b < NFAC; b++) begin
        push_pair(OP_LOAD_FLOW, a, b, (a == b) ? 0 : $urandom_range(0, 255));
        push_pair(OP_LOAD_DIST, a, b, (a == b) ? 0 : $urandom_range(0, 255));
      end
      push_beat(OP_LOAD_ASG, a, 0, a);
      push_beat(OP_LOAD_LIST, a, 0, a);
    end
    settle();

    // Directed: full size with no pair scanned, diagonal and value extremes
    write_cfg(CFG_START, 31);
    push_beat(OP_LOAD_FLOW, 0, 0, 16'hFFFF);
    push_beat(OP_LOAD_DIST, 31, 31, 16'hFFFF);
    push_pair(OP_LOAD_FLOW, 0, 31, 16'hFFFF);
    push_pair(OP_LOAD_DIST, 31, 0, 0);
    push_beat(OP_LOAD_ASG, 31, 0, 16'hFFFF);
    push_beat(OP_LOAD_LIST, 31, 0, 16'hFFFF);
    push_beat(opcode_e'(3'd5), 31, 31, 16'hFFFF);
    push_beat(opcode_e'(3'd6), 0, 0, 0);
    push_beat(opcode_e'(3'd7), 17, 9, 16'hA5A5);
    push_beat(OP_RUN, 0, 0, 0);
    settle();
    write_cfg(CFG_START, 28);
    push_beat(OP_RUN, 31, 31, 16'hFFFF);
    // Restore a zero diagonal before symmetric runs
    push_beat(OP_LOAD_FLOW, 0, 0, 0);
    push_beat(OP_LOAD_DIST, 31, 31, 0);
    settle();
    // Size below range, symmetric mode, swapped pair
    write_cfg(CFG_SIZE, 0);
    write_cfg(CFG_START, 0);
    write_cfg(CFG_MODE, 1);
    push_beat(OP_LOAD_ASG, 0, 0, 1);
    push_beat(OP_LOAD_ASG, 1, 0, 0);
    push_beat(OP_RUN, 0, 0, 0);
    settle();
    // Size above range, one pair at the top of the list
    write_cfg(CFG_SIZE, 63);
    write_cfg(CFG_START, 30);
    push_beat(OP_RUN, 0, 0, 0);
    settle();
    write_cfg(CFG_SIZE, 2);
    write_cfg(CFG_MODE, 0);
    push_beat(OP_RUN, 0, 0, 0);

    // Random phases: fresh permutation, symmetric matrix edits, list edits, runs
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      set_idling(ph % 4);
      n = $urandom_range(3, 6);
      write_cfg(CFG_SIZE, n);
      write_cfg(CFG_START, $urandom_range(0, 1));
      write_cfg(CFG_MODE, $urandom_range(0, 1));
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < n; k++) perm[k] = k;
      for (int k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      for (int k = 0; k < n; k++)
        push_beat(OP_LOAD_ASG, k, $urandom_range(0, 31), ($urandom_range(0, 2047) << 5) | perm[k]);
      for (int run = 0; run < 3; run++) begin
        repeat (3) begin
          r = $urandom_range(0, 31);
          c = (r + $urandom_range(1, 31)) % NFAC;
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
          push_pair($urandom_range(0, 1) ? OP_LOAD_DIST : OP_LOAD_FLOW, r, c, v);
        end
        push_beat(OP_LOAD_LIST, $urandom_range(0, n - 1), $urandom_range(0, 31),
                  ($urandom_range(0, 2047) << 5) | $urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0)
          push_beat(opcode_e'($urandom_range(5, 7)), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535));
        push_beat(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 65535));
      end
    end

    settle();
    $display("covered %0d load beats and %0d runs, %0d result beats checked", n_loads, n_runs,
             n_checked);
    $display("sizes 2..32 incl. out-of-range, both delta modes, empty scan, input back-pressure");
    if (n_errors == 0) begin
      $display("tb_pairwise_exchange_local_search_top: clean");
    end else begin
      $display("tb_pairwise_exchange_local_search_top: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pels_pkg.sv
hw/rtl/pels_in_if.sv
hw/rtl/pels_out_if.sv
hw/rtl/pels_mac_mem.sv
hw/rtl/pairwise_exchange_local_search_top.sv
hw/rtl/pels_chk.sv
sim/tb_pairwise_exchange_local_search_top.sv
